// File: rtl/ryp_pkg.sv
// Shared types, register codes and constants of the RGB to YUV 4:2:2 pixel packer.
`timescale 1ns / 1ps

package ryp_pkg;

    // Output packing codes held in the format register.
    localparam logic [2:0] FMT_YUY2   = 3'd0;
    localparam logic [2:0] FMT_UYVY   = 3'd1;
    localparam logic [2:0] FMT_RGB32  = 3'd2;
    localparam logic [2:0] FMT_RGB565 = 3'd3;
    localparam logic [2:0] FMT_RGB555 = 3'd4;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_FORMAT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RED_SHIFT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN_SHIFT   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE_SHIFT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RED_BITS      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN_BITS    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE_BITS     = 3'd6;

    // Component lanes.
    localparam int NUM_COMP = 3;
    localparam int COMP_R   = 0;
    localparam int COMP_G   = 1;
    localparam int COMP_B   = 2;

    // Widest component field that can be extracted.
    localparam int FIELD_W = 15;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Q8 color coefficients and limits.
    localparam logic [16:0] COEF_Y_R  = 17'd74;
    localparam logic [16:0] COEF_Y_G  = 17'd151;
    localparam logic [16:0] COEF_Y_B  = 17'd36;
    localparam logic [16:0] COEF_U_R  = 17'd36;
    localparam logic [16:0] COEF_U_G  = 17'd74;
    localparam logic [16:0] COEF_U_B  = 17'd110;
    localparam logic [16:0] COEF_V_R  = 17'd92;
    localparam logic [16:0] COEF_V_G  = 17'd74;
    localparam logic [16:0] COEF_V_B  = 17'd18;
    localparam logic [16:0] CHROMA_OFS = 17'd32768;
    localparam logic [7:0]  Y_MAX      = 8'd235;
    localparam logic [7:0]  C_MAX      = 8'd240;

    // What the front decided for one accepted word.
    typedef enum logic [1:0] {
        KIND_DROP,
        KIND_HOLD,
        KIND_PAIR,
        KIND_EMIT
    } kind_t;

    // Configuration seen by the front and the back.
    typedef struct packed {
        logic [2:0]                fmt;
        logic [NUM_COMP-1:0][4:0]  shift;
        logic [NUM_COMP-1:0][3:0]  bits;
    } cfg_t;

    // Rounded-up 2^24 / (2^w - 1) for field widths up to eight bits.
    function automatic logic [24:0] recip_q24(input logic [3:0] w);
        logic [24:0] r;
        unique case (w)
            4'd1:    r = 25'd16777216;
            4'd2:    r = 25'd5592406;
            4'd3:    r = 25'd2396746;
            4'd4:    r = 25'd1118482;
            4'd5:    r = 25'd541201;
            4'd6:    r = 25'd266306;
            4'd7:    r = 25'd132105;
            4'd8:    r = 25'd65794;
            default: r = 25'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ryp_front.sv
// Front end: accepts pixel words and classifies them against the pair state.
`timescale 1ns / 1ps

module ryp_front import ryp_pkg::*; #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,     // pixel_word[31:0]
    input  logic                  s_tlast,
    input  logic                  q_full,
    output logic                  q_push,
    output logic [PIXEL_BITS-1:0] q_pix,
    output kind_t                 q_kind
);

    logic  pend_reg;
    logic  pend_next;
    logic  accept;
    kind_t kind;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Pairs: first held, second emits, lone tlast word dropped; RGB emits.
    always_comb
    begin
        kind      = KIND_DROP;
        pend_next = pend_reg;
        if (accept)
        begin
            unique case (cfg.fmt) inside
                FMT_YUY2, FMT_UYVY:
                begin
                    if (pend_reg)
                    begin
                        kind      = KIND_PAIR;
                        pend_next = 1'b0;
                    end
                    else if (!s_tlast)
                    begin
                        kind      = KIND_HOLD;
                        pend_next = 1'b1;
                    end
                end
                FMT_RGB32, FMT_RGB565, FMT_RGB555:
                begin
                    kind      = KIND_EMIT;
                    pend_next = 1'b0;
                end
                default:
                begin
                    pend_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Dropped words never enter the queue.
    assign q_push = accept && (kind != KIND_DROP);
    assign q_pix  = s_tdata[PIXEL_BITS-1:0];
    assign q_kind = kind;

endmodule

// File: rtl/ryp_queue.sv
// Short queue of classified pixel words between front and back.
`timescale 1ns / 1ps

module ryp_queue import ryp_pkg::*; #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [PIXEL_BITS-1:0] push_pix,
    input  kind_t                 push_kind,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output logic [PIXEL_BITS-1:0] head_pix,
    output kind_t                 head_kind
);

    logic [PIXEL_BITS-1:0] pix_reg  [QUEUE_DEPTH];
    kind_t                 kind_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg;
    logic [QCNT_W-1:0]     count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_pix  = pix_reg[rd_ptr_reg];
    assign head_kind = kind_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pix_reg[wr_ptr_reg]  <= push_pix;
            kind_reg[wr_ptr_reg] <= push_kind;
        end
    end

endmodule

// File: rtl/ryp_back.sv
// Back end: component scaling, color conversion, pairing and output packing.
`timescale 1ns / 1ps

module ryp_back import ryp_pkg::*; #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  q_empty,
    input  logic [PIXEL_BITS-1:0] q_pix,
    input  kind_t                 q_kind,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata      // out_word[31:0]
);

    // Pipeline advance: everything moves unless the output word is stuck.
    logic en;

    // Per-component width and mask.
    logic [3:0]  w    [NUM_COMP];
    logic [15:0] mask [NUM_COMP];
    logic        big  [NUM_COMP];

    // Stage 1: extracted fields.
    logic [31:0]        word32;
    logic [31:0]        shifted [NUM_COMP];
    logic [FIELD_W-1:0] c_next  [NUM_COMP];
    logic               s1_valid_reg;
    kind_t              s1_kind_reg;
    logic [FIELD_W-1:0] s1_c_reg [NUM_COMP];

    // Stage 2: both scaling paths.
    logic [15:0] xs     [NUM_COMP];
    logic [40:0] prod   [NUM_COMP];
    logic [22:0] xb     [NUM_COMP];
    logic [22:0] xb_sh  [NUM_COMP];
    logic [7:0]  a      [NUM_COMP];
    logic [15:0] sum_ab [NUM_COMP];
    logic [7:0]  qb_next [NUM_COMP];
    logic        s2_valid_reg;
    kind_t       s2_kind_reg;
    logic [7:0]  s2_qs_reg [NUM_COMP];
    logic [7:0]  s2_qb_reg [NUM_COMP];

    // Stage 3: color values and straight RGB packing.
    logic [7:0]  comp [NUM_COMP];
    logic [16:0] ysum;
    logic [16:0] usum;
    logic [16:0] vsum;
    logic [7:0]  y_next;
    logic [7:0]  u_next;
    logic [7:0]  v_next;
    logic [31:0] rgb_next;
    logic        s3_valid_reg;
    kind_t       s3_kind_reg;
    logic [7:0]  s3_y_reg;
    logic [7:0]  s3_u_reg;
    logic [7:0]  s3_v_reg;
    logic [31:0] s3_rgb_reg;

    // Pairing and output register.
    logic [8:0]  cu_sum;
    logic [8:0]  cv_sum;
    logic [7:0]  cu;
    logic [7:0]  cv;
    logic [31:0] out_word_next;
    logic        out_valid_next;
    logic        hold_en;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [7:0]  held_luma_reg;
    logic [7:0]  held_cb_reg;
    logic [7:0]  held_cr_reg;

    assign en       = !out_valid_reg || m_tready;
    assign q_pop    = en && !q_empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;

    // A zero width reads as one bit; widths above eight take the long path.
    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            w[i]    = (cfg.bits[i] == 4'd0) ? 4'd1 : cfg.bits[i];
            mask[i] = (16'd1 << w[i]) - 16'd1;
            big[i]  = (w[i] > 4'd8);
        end
    end

    // Field extraction; bits beyond the word read as zero.
    always_comb
    begin
        word32 = 32'(q_pix);
        for (int i = 0; i < NUM_COMP; i++)
        begin
            shifted[i] = word32 >> cfg.shift[i];
            c_next[i]  = shifted[i][FIELD_W-1:0] & mask[i][FIELD_W-1:0];
        end
    end

    // Scaling c*255/(2^w-1). Narrow fields use a reciprocal multiply; wide
    // fields split the dividend at bit w, which leaves one correction step.
    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            xs[i]      = {s1_c_reg[i][7:0], 8'd0} - {8'd0, s1_c_reg[i][7:0]};
            prod[i]    = 41'(xs[i]) * 41'(recip_q24(w[i]));
            xb[i]      = {s1_c_reg[i], 8'd0} - {8'd0, s1_c_reg[i]};
            xb_sh[i]   = xb[i] >> w[i];
            a[i]       = xb_sh[i][7:0];
            sum_ab[i]  = 16'(a[i]) + 16'(xb[i][FIELD_W-1:0] & mask[i][FIELD_W-1:0]);
            qb_next[i] = a[i] + 8'(sum_ab[i] >= mask[i]);
        end
    end

    // Q8 color conversion. U and V sums never go negative for 8-bit inputs.
    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            comp[i] = big[i] ? s2_qb_reg[i] : s2_qs_reg[i];
        end
        ysum = COEF_Y_R * 17'(comp[COMP_R]) + COEF_Y_G * 17'(comp[COMP_G])
             + COEF_Y_B * 17'(comp[COMP_B]);
        usum = CHROMA_OFS + COEF_U_B * 17'(comp[COMP_B])
             - COEF_U_R * 17'(comp[COMP_R]) - COEF_U_G * 17'(comp[COMP_G]);
        vsum = CHROMA_OFS + COEF_V_R * 17'(comp[COMP_R])
             - COEF_V_G * 17'(comp[COMP_G]) - COEF_V_B * 17'(comp[COMP_B]);
        y_next = (ysum[16:8] > 9'(Y_MAX)) ? Y_MAX : ysum[15:8];
        u_next = (usum[16:8] > 9'(C_MAX)) ? C_MAX : usum[15:8];
        v_next = (vsum[16:8] > 9'(C_MAX)) ? C_MAX : vsum[15:8];

        case (cfg.fmt)
            FMT_RGB565:
                rgb_next = {16'd0, comp[COMP_R][7:3], comp[COMP_G][7:2], comp[COMP_B][7:3]};
            FMT_RGB555:
                rgb_next = {17'd0, comp[COMP_R][7:3], comp[COMP_G][7:3], comp[COMP_B][7:3]};
            default:
                rgb_next = {8'd0, comp[COMP_R], comp[COMP_G], comp[COMP_B]};
        endcase
    end

    // Pair completion with truncated chroma average, or a straight RGB word.
    always_comb
    begin
        cu_sum = 9'(held_cb_reg) + 9'(s3_u_reg);
        cv_sum = 9'(held_cr_reg) + 9'(s3_v_reg);
        cu     = cu_sum[8:1];
        cv     = cv_sum[8:1];
        if (s3_kind_reg == KIND_PAIR)
        begin
            if (cfg.fmt == FMT_UYVY)
            begin
                out_word_next = {s3_y_reg, cv, held_luma_reg, cu};
            end
            else
            begin
                out_word_next = {cv, s3_y_reg, cu, held_luma_reg};
            end
        end
        else
        begin
            out_word_next = s3_rgb_reg;
        end
        out_valid_next = s3_valid_reg
                       && ((s3_kind_reg == KIND_PAIR) || (s3_kind_reg == KIND_EMIT));
        hold_en        = en && s3_valid_reg && (s3_kind_reg == KIND_HOLD);
    end

    // Control state of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_luma_reg <= 8'd0;
            held_cb_reg   <= 8'd0;
            held_cr_reg   <= 8'd0;
        end
        else
        begin
            if (en)
            begin
                s1_valid_reg  <= !q_empty;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= out_valid_next;
            end
            if (hold_en)
            begin
                held_luma_reg <= s3_y_reg;
                held_cb_reg   <= s3_u_reg;
                held_cr_reg   <= s3_v_reg;
            end
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg  <= q_kind;
            s2_kind_reg  <= s1_kind_reg;
            s3_kind_reg  <= s2_kind_reg;
            s3_y_reg     <= y_next;
            s3_u_reg     <= u_next;
            s3_v_reg     <= v_next;
            s3_rgb_reg   <= rgb_next;
            out_word_reg <= out_word_next;
            for (int i = 0; i < NUM_COMP; i++)
            begin
                s1_c_reg[i]  <= c_next[i];
                s2_qs_reg[i] <= prod[i][31:24];
                s2_qb_reg[i] <= qb_next[i];
            end
        end
    end

endmodule

// File: rtl/rgb_to_yuv422_pixel_packer_unit.sv
// Top level of the RGB to YUV 4:2:2 / RGB pixel packer.
//
// Channel  Direction  tdata                 tlast    Notes
// s_*      in         pixel_word[31:0]      row_end  source pixels
// m_*      out        out_word[31:0]        -        packed macropixel or RGB word
// cfg_*    in         cfg_wdata[4:0]        -        cfg_addr selects the register
//
// One word per cycle is taken while m_tready is high, and given in the RGB
// formats; each component owns one multiplier in the scaling stage, used once
// per word. An accepted word is written into the queue at its accepting edge
// and then passes the three back stages and the output register on its way to m_tvalid.
// Reset clears the pair state, the queue and all stage valids, and loads the
// registers with YUY2 and 8-bit fields at bit 16, 8 and 0.
// m_tready low with m_tvalid high freezes the back pipeline; the four-word queue then fills and
// s_tready drops only when it is full.
`timescale 1ns / 1ps

module rgb_to_yuv422_pixel_packer_unit import ryp_pkg::*; #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,     // pixel_word[31:0]
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,     // out_word[31:0]
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t                  cfg_reg;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    logic [PIXEL_BITS-1:0] q_in_pix;
    kind_t                 q_in_kind;
    logic [PIXEL_BITS-1:0] q_head_pix;
    kind_t                 q_head_kind;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fmt           <= FMT_YUY2;
            cfg_reg.shift[COMP_R] <= 5'd16;
            cfg_reg.shift[COMP_G] <= 5'd8;
            cfg_reg.shift[COMP_B] <= 5'd0;
            cfg_reg.bits[COMP_R]  <= 4'd8;
            cfg_reg.bits[COMP_G]  <= 4'd8;
            cfg_reg.bits[COMP_B]  <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_OUTPUT_FORMAT: cfg_reg.fmt           <= cfg_wdata[2:0];
                REG_RED_SHIFT:     cfg_reg.shift[COMP_R] <= cfg_wdata;
                REG_GREEN_SHIFT:   cfg_reg.shift[COMP_G] <= cfg_wdata;
                REG_BLUE_SHIFT:    cfg_reg.shift[COMP_B] <= cfg_wdata;
                REG_RED_BITS:      cfg_reg.bits[COMP_R]  <= cfg_wdata[3:0];
                REG_GREEN_BITS:    cfg_reg.bits[COMP_G]  <= cfg_wdata[3:0];
                REG_BLUE_BITS:     cfg_reg.bits[COMP_B]  <= cfg_wdata[3:0];
                default:           ;
            endcase
        end
    end

    ryp_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_pix    (q_in_pix),
        .q_kind   (q_in_kind)
    );

    ryp_queue #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_pix  (q_in_pix),
        .push_kind (q_in_kind),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head_pix  (q_head_pix),
        .head_kind (q_head_kind)
    );

    ryp_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_pix    (q_head_pix),
        .q_kind   (q_head_kind),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/ryp_checker.sv
// Port-level checker for the pixel packer and its bind to the top level.
`timescale 1ns / 1ps

module ryp_checker import ryp_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Words accepted minus words delivered; sticks once it saturates.
    logic [15:0] credit_reg;
    logic [15:0] credit_next;
    logic        s_acc;
    logic        m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb
    begin
        credit_next = credit_reg;
        if (credit_reg != '1)
        begin
            if (s_acc && !m_acc)
            begin
                credit_next = credit_reg + 16'd1;
            end
            else if (m_acc && !s_acc)
            begin
                credit_next = credit_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Every delivered word was caused by an earlier accepted word.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_acc |-> credit_reg != 16'd0)
        else $error("output word without a prior input word");

    // The top byte is a luma, an averaged red-difference chroma or zero.
    a_top_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:24] <= Y_MAX)
        else $error("top output byte out of range");

    // Nothing is offered in the first cycle after reset.
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind rgb_to_yuv422_pixel_packer_unit ryp_checker u_ryp_checker (.*);
